FILE: design/fqs_pkg.sv
package fqs_pkg;

	// default queue depth
	localparam int DEPTH_DEF = 16;

	// stream payload widths, rounded up to whole bytes
	localparam int CMD_W       = 2;
	localparam int VAL_W       = 32;
	localparam int STATUS_W    = 2;
	localparam int OCC_W       = 5;
	localparam int IN_RAW_W    = CMD_W + VAL_W;
	localparam int IN_TDATA_W  = ((IN_RAW_W + 7) / 8) * 8;
	localparam int OUT_RAW_W   = STATUS_W + 1 + VAL_W + OCC_W + 1;
	localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;

	// command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH   = 2'd0,
		CMD_POP    = 2'd1,
		CMD_SEARCH = 2'd2
	} cmd_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_HREAD,
		S_HWAIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic ld_in;      // capture the incoming transfer
		logic exec;       // apply push / pop, arm the search
		logic scan_step;  // read one held entry for the search
		logic ld_out;     // load the result register
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_search;  // latched command is a search
		logic cnt_zero;   // queue holds nothing
		logic scan_last;  // this scan step reads the last held entry
		logic out_free;   // result register can take a new result
	} dp_stat_t;

endpackage

FILE: design/fqs_ctrl.sv
module fqs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  fqs_pkg::dp_stat_t stat,
	output fqs_pkg::dp_cmd_t  cmd
);

	fqs_pkg::state_t state_q, state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fqs_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			fqs_pkg::S_IDLE: begin
				if (s_tvalid) state_nxt = fqs_pkg::S_EXEC;
			end
			fqs_pkg::S_EXEC: begin
				if (stat.is_search && !stat.cnt_zero) state_nxt = fqs_pkg::S_SCAN;
				else state_nxt = fqs_pkg::S_HREAD;
			end
			fqs_pkg::S_SCAN: begin
				if (stat.scan_last) state_nxt = fqs_pkg::S_HREAD;
			end
			fqs_pkg::S_HREAD: begin
				state_nxt = fqs_pkg::S_HWAIT;
			end
			fqs_pkg::S_HWAIT: begin
				if (stat.out_free) state_nxt = fqs_pkg::S_IDLE;
			end
			default: begin
				state_nxt = fqs_pkg::S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		s_tready      = 1'b0;
		cmd           = '0;
		case (state_q)
			fqs_pkg::S_IDLE: begin
				s_tready  = 1'b1;
				cmd.ld_in = s_tvalid;
			end
			fqs_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
			end
			fqs_pkg::S_SCAN: begin
				cmd.scan_step = 1'b1;
			end
			fqs_pkg::S_HREAD: begin
				cmd = '0;
			end
			fqs_pkg::S_HWAIT: begin
				cmd.ld_out = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

FILE: design/fqs_dp.sv
module fqs_dp #(
	parameter int DEPTH = fqs_pkg::DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [fqs_pkg::IN_TDATA_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [fqs_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  fqs_pkg::dp_cmd_t                cmd,
	output fqs_pkg::dp_stat_t               stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [fqs_pkg::VAL_W-1:0]       mem [DEPTH];
	logic [fqs_pkg::VAL_W-1:0]       rd_q;
	logic [AW-1:0]                   rd_addr;

	logic [fqs_pkg::CMD_W-1:0]       cmd_q;
	logic [fqs_pkg::VAL_W-1:0]       val_q;
	logic [AW-1:0]                   head_q, tail_q, idx_q;
	logic [CW-1:0]                   cnt_q, left_q;
	logic                            cmp_vld_s1;
	logic                            found_q;
	fqs_pkg::status_t                status_q;
	logic                            out_vld_q;
	logic [fqs_pkg::OUT_TDATA_W-1:0] out_data_q;

	logic                            full, push_ok;
	logic [AW-1:0]                   head_nxt, tail_nxt, idx_nxt;
	logic [fqs_pkg::VAL_W-1:0]       head_val;
	logic [fqs_pkg::OUT_RAW_W-1:0]   res_raw;

	// ring index increments
	assign head_nxt = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_nxt = (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
	assign idx_nxt  = (idx_q == AW'(DEPTH - 1)) ? '0 : idx_q + 1'b1;

	assign full    = (cnt_q == CW'(DEPTH));
	assign push_ok = cmd.exec && (fqs_pkg::cmd_t'(cmd_q) == fqs_pkg::CMD_PUSH) && !full;

	// single read port: scan walks idx, otherwise the head is read
	assign rd_addr = cmd.scan_step ? idx_q : head_q;

	// entry memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (push_ok) mem[tail_q] <= val_q;
		rd_q <= mem[rd_addr];
	end

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			cmd_q <= s_tdata[fqs_pkg::CMD_W-1:0];
			val_q <= s_tdata[fqs_pkg::IN_RAW_W-1:fqs_pkg::CMD_W];
		end
	end

	// queue pointers, count and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			cnt_q    <= '0;
			status_q <= fqs_pkg::STAT_OK;
		end else if (cmd.exec) begin
			status_q <= fqs_pkg::STAT_OK;
			case (fqs_pkg::cmd_t'(cmd_q))
				fqs_pkg::CMD_PUSH: begin
					if (full) begin
						status_q <= fqs_pkg::STAT_FULL;
					end else begin
						tail_q <= tail_nxt;
						cnt_q  <= cnt_q + 1'b1;
					end
				end
				fqs_pkg::CMD_POP: begin
					if (cnt_q == '0) begin
						status_q <= fqs_pkg::STAT_EMPTY;
					end else begin
						head_q <= head_nxt;
						cnt_q  <= cnt_q - 1'b1;
					end
				end
				default: begin
					status_q <= fqs_pkg::STAT_OK;
				end
			endcase
		end
	end

	// search walk: issue one read per cycle, compare each entry in the cycle after its read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			left_q     <= '0;
			cmp_vld_s1 <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			cmp_vld_s1 <= cmd.scan_step;
			if (cmd.exec) begin
				idx_q   <= head_q;
				left_q  <= cnt_q;
				found_q <= 1'b0;
			end else begin
				if (cmd.scan_step) begin
					idx_q  <= idx_nxt;
					left_q <= left_q - 1'b1;
				end
				if (cmp_vld_s1 && (rd_q == val_q)) found_q <= 1'b1;
			end
		end
	end

	// result assembly
	assign head_val = (cnt_q == '0) ? '0 : rd_q;
	assign res_raw  = {(cnt_q == '0), fqs_pkg::OCC_W'(cnt_q), head_val, found_q, status_q};

	always_ff @(posedge clk) begin
		if (cmd.ld_out) out_data_q <= fqs_pkg::OUT_TDATA_W'(res_raw);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.ld_out) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

	// status to controller
	assign stat.is_search = (fqs_pkg::cmd_t'(cmd_q) == fqs_pkg::CMD_SEARCH);
	assign stat.cnt_zero  = (cnt_q == '0);
	assign stat.scan_last = (left_q == CW'(1));
	assign stat.out_free  = !out_vld_q || m_tready;

endmodule

FILE: design/fifo_queue_with_search.sv
// Bounded FIFO of DEPTH signed 32-bit values with push, pop and a membership
// search. Each command yields one result: status (ok, push dropped on full,
// pop on empty), search hit flag, the head value after the command (zero when
// empty), the occupancy (low 5 bits of the count) and an empty flag. Entries
// live in a single-port-read RAM with registered output, so the head and every
// searched entry are fetched one per cycle: push, pop and unused codes pass
// through idle, execute, head-read and head-wait; a search adds one scan
// step per held entry. One finished result is held in an output register, so
// a stalled consumer only holds the block once a second result is ready.
module fifo_queue_with_search #(
	parameter int DEPTH = fqs_pkg::DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [1:0] cmd, [33:2] value, rest zero
	input  logic [fqs_pkg::IN_TDATA_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [1:0] status, [2] found, [34:3] head_value, [39:35] occupancy,
	// [40] is_empty, rest zero
	output logic [fqs_pkg::OUT_TDATA_W-1:0] m_tdata
);

	fqs_pkg::dp_cmd_t  dp_cmd;
	fqs_pkg::dp_stat_t dp_stat;

	fqs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	fqs_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (dp_cmd),
		.stat     (dp_stat)
	);

endmodule

FILE: tb/fifo_queue_with_search_tb.sv
module fifo_queue_with_search_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QDEPTH = fqs_pkg::DEPTH_DEF;
	localparam int QAW = $clog2(QDEPTH);
	localparam logic [fqs_pkg::CMD_W-1:0] CMD_NOP = 2'd3;  // unused code, no operation
	localparam int DRAIN_CYCLES = 2 * QDEPTH + 10;
	localparam int RANDOM_ITEMS = 1900;

	// the fields of one result as the checker reads them from m_tdata
	typedef struct packed {
		fqs_pkg::status_t          status;
		logic                      found;
		logic signed [31:0]        head_value;
		logic [fqs_pkg::OCC_W-1:0] occupancy;
		logic                      is_empty;
	} queue_result_t;

	// directed stimulus row; rows with reps > 1 push val, val+1, ...
	typedef struct {
		logic [fqs_pkg::CMD_W-1:0] op;
		logic [31:0]               val;
		int                        reps;
		bit                        typed;
		queue_result_t             res;
	} stim_row_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	// [1:0] cmd, [33:2] value, rest zero
	logic [fqs_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	// [1:0] status, [2] found, [34:3] head_value, [39:35] occupancy,
	// [40] is_empty, rest zero
	logic [fqs_pkg::OUT_TDATA_W-1:0] m_tdata;

	// queue state as the testbench tracks it
	logic [31:0] ring_q [QDEPTH];
	int          ring_head = 0;
	int          ring_tail = 0;
	int          ring_count = 0;

	queue_result_t pending_results [$];
	queue_result_t want;
	int            mismatch_count = 0;

	// sender burst / gap state
	int burst_left = 0;
	int gap_len;

	// receiver stall state
	int         stall_mode = 0;
	int         stall_left = 0;
	logic [2:0] stall_pos = 3'd0;
	logic [7:0] stall_pat = 8'b1011_0010;

	stim_row_t directed_rows [17] = '{
		'{fqs_pkg::CMD_POP,    32'h0,        1,  1,
			'{fqs_pkg::STAT_EMPTY, 1'b0, 32'h0, 5'd0, 1'b1}},
		'{fqs_pkg::CMD_SEARCH, 32'h0,        1,  1,
			'{fqs_pkg::STAT_OK, 1'b0, 32'h0, 5'd0, 1'b1}},
		'{CMD_NOP,             32'hFFFFFFFF, 1,  1,
			'{fqs_pkg::STAT_OK, 1'b0, 32'h0, 5'd0, 1'b1}},
		'{fqs_pkg::CMD_PUSH,   32'h80000000, 1,  1,
			'{fqs_pkg::STAT_OK, 1'b0, 32'h80000000, 5'd1, 1'b0}},
		'{fqs_pkg::CMD_PUSH,   32'h7FFFFFFF, 1,  1,
			'{fqs_pkg::STAT_OK, 1'b0, 32'h80000000, 5'd2, 1'b0}},
		'{fqs_pkg::CMD_SEARCH, 32'h7FFFFFFF, 1,  1,
			'{fqs_pkg::STAT_OK, 1'b1, 32'h80000000, 5'd2, 1'b0}},
		'{fqs_pkg::CMD_SEARCH, 32'h0,        1,  1,
			'{fqs_pkg::STAT_OK, 1'b0, 32'h80000000, 5'd2, 1'b0}},
		'{fqs_pkg::CMD_POP,    32'h0,        1,  1,
			'{fqs_pkg::STAT_OK, 1'b0, 32'h7FFFFFFF, 5'd1, 1'b0}},
		'{fqs_pkg::CMD_POP,    32'h0,        1,  1,
			'{fqs_pkg::STAT_OK, 1'b0, 32'h0, 5'd0, 1'b1}},
		'{fqs_pkg::CMD_PUSH,   32'd1000,     15, 0, '0},
		'{fqs_pkg::CMD_PUSH,   32'hFFFFFFFF, 1,  1,
			'{fqs_pkg::STAT_OK, 1'b0, 32'd1000, 5'd16, 1'b0}},
		'{fqs_pkg::CMD_PUSH,   32'd5,        1,  1,
			'{fqs_pkg::STAT_FULL, 1'b0, 32'd1000, 5'd16, 1'b0}},
		'{fqs_pkg::CMD_SEARCH, 32'hFFFFFFFF, 1,  1,
			'{fqs_pkg::STAT_OK, 1'b1, 32'd1000, 5'd16, 1'b0}},
		'{fqs_pkg::CMD_SEARCH, 32'd1007,     1,  0, '0},
		'{fqs_pkg::CMD_POP,    32'h0,        1,  0, '0},
		'{CMD_NOP,             32'h0,        1,  0, '0},
		'{fqs_pkg::CMD_SEARCH, 32'd1000,     1,  0, '0}
	};

	fifo_queue_with_search dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// apply one command to the tracked queue, return the result it yields
	function automatic queue_result_t queue_model_apply(logic [fqs_pkg::CMD_W-1:0] op,
			logic [31:0] val);
		queue_result_t r;
		int idx;
		r = '0;
		r.status = fqs_pkg::STAT_OK;
		case (op)
			fqs_pkg::CMD_PUSH: begin
				if (ring_count >= QDEPTH) begin
					r.status = fqs_pkg::STAT_FULL;
				end else begin
					ring_q[ring_tail[QAW-1:0]] = val;
					ring_tail = (ring_tail + 1 == QDEPTH) ? 0 : ring_tail + 1;
					ring_count++;
				end
			end
			fqs_pkg::CMD_POP: begin
				if (ring_count == 0) begin
					r.status = fqs_pkg::STAT_EMPTY;
				end else begin
					ring_head = (ring_head + 1 == QDEPTH) ? 0 : ring_head + 1;
					ring_count--;
				end
			end
			fqs_pkg::CMD_SEARCH: begin
				idx = ring_head;
				for (int k = 0; k < ring_count; k++) begin
					if (ring_q[idx[QAW-1:0]] == val)
						r.found = 1'b1;
					idx = (idx + 1 == QDEPTH) ? 0 : idx + 1;
				end
			end
			default: ;
		endcase
		if (ring_count != 0)
			r.head_value = ring_q[ring_head[QAW-1:0]];
		r.occupancy = ring_count[fqs_pkg::OCC_W-1:0];
		r.is_empty  = (ring_count == 0);
		return r;
	endfunction

	// extremes and small numbers for half the picks, full-range values otherwise
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h80000000;
			1: return 32'h7FFFFFFF;
			2: return ($urandom_range(0, 1)) ? 32'h0 : 32'hFFFFFFFF;
			3: return $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	// one command transfer; records the expected result once accepted
	task automatic send_cmd(input logic [fqs_pkg::CMD_W-1:0] op, input logic [31:0] val,
			input bit typed, input queue_result_t typed_res);
		logic [fqs_pkg::IN_TDATA_W-1:0] word;
		queue_result_t predicted;
		word = '0;
		word[fqs_pkg::CMD_W-1:0] = op;
		word[fqs_pkg::CMD_W +: fqs_pkg::VAL_W] = val;
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		do
			@(posedge clk);
		while (!s_tready);
		predicted = queue_model_apply(op, val);
		pending_results.push_back(typed ? typed_res : predicted);
		// bursts of random length, random gaps between them
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 20);
			gap_len = $urandom_range(1, 8);
			s_tvalid <= 1'b0;
			repeat (gap_len) @(posedge clk);
		end else begin
			burst_left--;
		end
	endtask

	// receiver readiness: free-running, random, sparse, or a fixed pattern
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(50, 300);
		end else begin
			stall_left--;
		end
		stall_pos = stall_pos + 3'd1;
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= ($urandom_range(0, 7) == 0);
			default: m_tready <= stall_pat[stall_pos];
		endcase
	end

	// result checker: every accepted transfer against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with nothing expected: m_tdata %h", m_tdata);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[1:0] !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_tdata[1:0]);
					mismatch_count++;
				end
				if (m_tdata[2] !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, m_tdata[2]);
					mismatch_count++;
				end
				if (m_tdata[34:3] !== want.head_value) begin
					$error("head_value: expected %0d, got %0d", want.head_value,
						$signed(m_tdata[34:3]));
					mismatch_count++;
				end
				if (m_tdata[39:35] !== want.occupancy) begin
					$error("occupancy: expected %0d, got %0d", want.occupancy,
						m_tdata[39:35]);
					mismatch_count++;
				end
				if (m_tdata[40] !== want.is_empty) begin
					$error("is_empty: expected %0d, got %0d", want.is_empty, m_tdata[40]);
					mismatch_count++;
				end
			end
		end
	end

	// stimulus
	initial begin
		logic [fqs_pkg::CMD_W-1:0] op;
		logic [31:0] val;
		int phase;
		int phase_left;
		int pick;
		int slot;
		phase = 3;
		phase_left = 0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows
		foreach (directed_rows[i]) begin
			for (int r = 0; r < directed_rows[i].reps; r++)
				send_cmd(directed_rows[i].op, directed_rows[i].val + r,
					directed_rows[i].typed, directed_rows[i].res);
		end

		// random phases: fill, drain, search-heavy, balanced
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (phase_left == 0) begin
				phase = $urandom_range(0, 3);
				phase_left = $urandom_range(30, 120);
			end else begin
				phase_left--;
			end
			pick = $urandom_range(0, 99);
			if (pick < 3)
				op = CMD_NOP;
			else
				case (phase)
					0: op = (pick < 70) ? fqs_pkg::CMD_PUSH
						: (pick < 85) ? fqs_pkg::CMD_POP : fqs_pkg::CMD_SEARCH;
					1: op = (pick < 20) ? fqs_pkg::CMD_PUSH
						: (pick < 80) ? fqs_pkg::CMD_POP : fqs_pkg::CMD_SEARCH;
					2: op = (pick < 25) ? fqs_pkg::CMD_PUSH
						: (pick < 40) ? fqs_pkg::CMD_POP : fqs_pkg::CMD_SEARCH;
					default: op = (pick < 40) ? fqs_pkg::CMD_PUSH
						: (pick < 70) ? fqs_pkg::CMD_POP : fqs_pkg::CMD_SEARCH;
				endcase
			// searches mostly look for a value that is held
			if (op == fqs_pkg::CMD_SEARCH && ring_count != 0 && $urandom_range(0, 9) < 6)
			begin
				slot = (ring_head + int'($urandom_range(0, ring_count - 1))) % QDEPTH;
				val = ring_q[slot[QAW-1:0]];
			end else begin
				val = pick_value();
			end
			send_cmd(op, val, 1'b0, '0);
		end
		s_tvalid <= 1'b0;

		// drain, then give the block time to show any stray result
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("fifo_queue_with_search_tb: clean");
		end else begin
			$display("fifo_queue_with_search_tb: errors");
		end
		$finish;
	end

	// watchdog
	initial begin
		#3_000_000;
		$display("fifo_queue_with_search_tb: errors");
		$finish;
	end

endmodule
